FILE: hw/rtl/bdq_pkg.sv
// Package for the bounded deque: sizes, operation and status codes,
// and the decode struct passed from the pointer logic to the top level.
// No dependencies.
package bdq_pkg;

    // deque capacity (entries)
    localparam int unsigned DEPTH = 8;
    // data word width
    localparam int unsigned DW    = 32;
    // store address width
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // fill counter width, holds 0..DEPTH
    localparam int unsigned FW    = $clog2(DEPTH + 1);
    // width of head + fill sums before wrap
    localparam int unsigned SW    = FW + 1;
    // width of the reported entry count
    localparam int unsigned CW    = 4;

    typedef enum logic [1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_PUSH_REAR  = 2'd1,
        FN_POP_FRONT  = 2'd2,
        FN_POP_REAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // decoded operation for the item being accepted
    typedef struct packed {
        logic              we;      // store write
        logic              re;      // store read (successful pop)
        logic [AW-1:0]     addr;    // store entry touched
        t_status           status;
        logic [CW-1:0]     count;   // entries after the operation
    } t_op_dec;

endpackage

FILE: hw/rtl/bdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package dependency.
module bdq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/bdq_ctrl.sv
// Head and fill pointers of the deque: decodes the operation against the
// current pointers and updates them when a beat is taken. Uses bdq_pkg.
module bdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  bdq_pkg::t_func   i_func,
    output bdq_pkg::t_op_dec o_dec
);
    import bdq_pkg::*;

    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;

    logic          is_full;
    logic          is_empty;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [SW-1:0] rear_sum;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] rear_idx;
    logic [AW-1:0] last_idx;
    t_op_dec       dec;

    // neighbor indexes with modulo-DEPTH wrap
    assign is_full  = (r_fill == FW'(DEPTH));
    assign is_empty = (r_fill == '0);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);

    // slot after the rear entry, and the rear entry itself
    assign rear_sum = SW'(r_head) + SW'(r_fill);
    assign last_sum = rear_sum - SW'(1);
    assign rear_idx = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);
    assign last_idx = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

    // operation decode
    always_comb begin
        n_head     = r_head;
        n_fill     = r_fill;
        dec.we     = 1'b0;
        dec.re     = 1'b0;
        dec.addr   = r_head;
        dec.status = ST_OK;
        case (i_func)
            FN_PUSH_FRONT: begin
                if (is_full) begin
                    dec.status = ST_FULL;
                end else begin
                    dec.we   = 1'b1;
                    dec.addr = head_dec;
                    n_head   = head_dec;
                    n_fill   = r_fill + FW'(1);
                end
            end
            FN_PUSH_REAR: begin
                if (is_full) begin
                    dec.status = ST_FULL;
                end else begin
                    dec.we   = 1'b1;
                    dec.addr = rear_idx;
                    n_fill   = r_fill + FW'(1);
                end
            end
            FN_POP_FRONT: begin
                if (is_empty) begin
                    dec.status = ST_EMPTY;
                end else begin
                    dec.re   = 1'b1;
                    dec.addr = r_head;
                    n_head   = head_inc;
                    n_fill   = r_fill - FW'(1);
                end
            end
            FN_POP_REAR: begin
                if (is_empty) begin
                    dec.status = ST_EMPTY;
                end else begin
                    dec.re   = 1'b1;
                    dec.addr = last_idx;
                    n_fill   = r_fill - FW'(1);
                end
            end
            default: begin
                dec.status = ST_OK;
            end
        endcase
        dec.count = CW'(n_fill);
    end

    assign o_dec = dec;

    // pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_step) begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    // pointers stay in range
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill above capacity");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= AW'(DEPTH - 1))
        else $error("head out of range");

    // a refused operation leaves the pointers untouched
    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (dec.status != ST_OK) |=> $stable(r_head) && $stable(r_fill))
        else $error("pointers moved on a refused operation");

endmodule

FILE: hw/rtl/bounded_deque_unit.sv
// Bounded double-ended queue of signed 32-bit words, top level.
// Instantiates bdq_ctrl and bdq_ram; uses bdq_pkg.

// Each input beat carries one operation (push front, push rear, pop front,
// pop rear) and yields exactly one result beat: the popped word (zero for
// pushes and refused pops), a status (ok, full, empty) and the entry count
// after the operation. The words live in a DEPTH-entry RAM with a
// registered read port; head and fill pointers sit in flip-flops. An item
// passes two steps: the RAM access and pointer update, then the move of the
// registered RAM read result into the output register. A new beat is taken
// only in the idle state, also while a finished result waits in the output
// register; the unit holds in the wait state only while that register is
// full and not being read. No clearing pass is needed after reset.
module bounded_deque_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // operation channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_func,
    input  logic signed [bdq_pkg::DW-1:0] i_data_in,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [bdq_pkg::DW-1:0] o_data_out,
    output logic [1:0]                  o_status,
    output logic [bdq_pkg::CW-1:0]      o_count
);
    import bdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WAIT = 2'b10
    } t_state;

    t_state        r_state, n_state;
    t_op_dec       dec;
    logic          in_take;
    logic          out_free;
    logic          res_load;
    logic [DW-1:0] ram_rdata;

    // pending result while the RAM read completes
    logic          r_pend_pop;
    t_status       r_pend_status;
    logic [CW-1:0] r_pend_count;

    // output register
    logic          r_out_valid;
    logic [DW-1:0] r_data_out;
    t_status       r_status;
    logic [CW-1:0] r_count;

    // handshake
    assign o_in_ready = (r_state == S_IDLE);
    assign in_take    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign res_load   = (r_state == S_WAIT) && out_free;

    // pointer logic
    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_take),
        .i_func  (t_func'(i_func)),
        .o_dec   (dec)
    );

    // word store
    bdq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_take && dec.we),
        .i_waddr (dec.addr),
        .i_wdata (i_data_in),
        .i_re    (in_take && dec.re),
        .i_raddr (dec.addr),
        .o_rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture decode results at accept
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_pend_pop    <= dec.re;
            r_pend_status <= dec.status;
            r_pend_count  <= dec.count;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_data_out <= r_pend_pop ? ram_rdata : '0;
            r_status   <= r_pend_status;
            r_count    <= r_pend_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_count     = r_count;

    // the store is never read and written in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_take && dec.we && dec.re))
        else $error("store read and write in one cycle");

    // a refused push reports a full deque
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_status == ST_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status with wrong count");

    // a refused pop reports zero entries and zero data
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_status == ST_EMPTY) |-> (r_count == '0) && (r_data_out == '0))
        else $error("empty status with nonzero count or data");

    // every accepted beat is followed by the wait state
    a_take_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == S_WAIT))
        else $error("accepted beat not followed by wait state");

endmodule
